/* sv/vrsf_pkg.sv */
`timescale 1ns / 1ps
// vrsf_pkg: shared types, character codes and the terminal model decode
// for the videotex reply sequence filter. No dependencies.

package vrsf_pkg;

  // Control characters of the terminal protocol
  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_GS    = 8'h1D;
  localparam logic [7:0] CH_US    = 8'h1F;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Escape protocol replies that are skipped whole
  localparam logic [7:0] ESC_SKIP_ONE   = 8'd57;
  localparam logic [7:0] ESC_SKIP_TWO   = 8'd58;
  localparam logic [7:0] ESC_SKIP_THREE = 8'd59;
  // ESC followed by a byte in this range keeps both bytes
  localparam logic [7:0] ESC_KEEP_LO    = 8'd64;
  localparam logic [7:0] ESC_KEEP_HI    = 8'd93;

  // Cursor report bias and the value given for a missing coordinate
  localparam logic [7:0] CURSOR_BIAS    = 8'h40;
  localparam logic [7:0] CURSOR_MISSING = 8'hC0;

  // Model codes
  localparam logic [7:0] MODEL_DEFAULT  = 8'h62;
  localparam logic [7:0] MODEL_V_BASIC  = 8'h76;
  localparam logic [7:0] MODEL_V_PLUS   = 8'h80;
  localparam logic [7:0] CH_LOWER_V     = 8'h76;
  localparam logic [7:0] CH_UPPER_B     = 8'h42;
  localparam logic [7:0] CH_UPPER_P     = 8'h50;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_OFF     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TELINFO_MODE   = 2'd2;

  // Channel payloads
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_beat_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] out_byte;
    logic       last;
    logic [7:0] terminal_type;
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
    logic       cursor_seen;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load_lit0;
    logic load_lit1;
    logic load_mem;
    logic load_stat;
  } ctrl_cmd_t;

  // Datapath to controller status: the plan of the last accepted beat
  typedef struct packed {
    logic       rel_pre;
    logic       rel_post;
    logic [1:0] lit_cnt;
    logic       has_stat;
    logic       idx_done;
    logic       slot_free;
  } dp_sts_t;

  // Terminal model from the second and third bytes of an identity reply
  function automatic logic [7:0] decode_model(input logic [7:0] third,
                                              input logic [7:0] second,
                                              input logic [7:0] cur);
    logic [7:0] code;
    code = MODEL_DEFAULT;
    case (third)
      8'h62, 8'h63, 8'h72, 8'h73, 8'h64,
      8'h66, 8'h75, 8'h77, 8'h79, 8'h7A: begin  // b c r s d f u w y z
        code = third;
      end
      CH_LOWER_V: begin
        if (second == CH_UPPER_B) begin
          code = MODEL_V_BASIC;
        end else if (second == CH_UPPER_P) begin
          code = MODEL_V_PLUS;
        end else begin
          code = cur;
        end
      end
      default: begin
        code = MODEL_DEFAULT;
      end
    endcase
    return code;
  endfunction

endpackage

/* sv/vrsf_if.sv */
`timescale 1ns / 1ps
// vrsf_in_if / vrsf_out_if: valid/ready channels carrying the input and
// result beats. Depends on vrsf_pkg.

interface vrsf_in_if;
  import vrsf_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vrsf_out_if;
  import vrsf_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/vrsf_datapath.sv */
`timescale 1ns / 1ps
// vrsf_datapath: parse state, hold memory, beat plan and output register.
// Depends on vrsf_pkg; driven by vrsf_ctrl through ctrl_cmd_t.

module vrsf_datapath #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  vrsf_pkg::in_beat_t               in_data,
  input  logic                             cfg_we,
  input  logic [vrsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                             cfg_wdata,
  input  vrsf_pkg::ctrl_cmd_t              cmd,
  output vrsf_pkg::dp_sts_t                sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output vrsf_pkg::out_beat_t              out_data
);
  import vrsf_pkg::*;

  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int AW = $clog2(HOLD_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(HOLD_DEPTH);

  // Parse phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HOLD  = 3'd1;
  localparam logic [2:0] PH_US1   = 3'd2;
  localparam logic [2:0] PH_US2   = 3'd3;
  localparam logic [2:0] PH_ESC1  = 3'd4;
  localparam logic [2:0] PH_ESCGS = 3'd5;
  localparam logic [2:0] PH_SKIP  = 3'd6;
  localparam logic [2:0] PH_PASS  = 3'd7;

  // Configuration
  logic chan_active_r, filter_off_r, telinfo_r;

  // Parse state
  logic [2:0]    phase_r, phase_nxt;
  logic [1:0]    skip_r, skip_nxt;
  logic [CW-1:0] hold_cnt_r, hold_cnt_nxt;
  logic [7:0]    second_r, second_nxt;
  logic [7:0]    third_r, third_nxt;
  logic [7:0]    rowp_r, rowp_nxt;
  logic [7:0]    model_r, model_nxt;
  logic [7:0]    row_r, row_nxt;
  logic [7:0]    col_r, col_nxt;
  logic          seen_r, seen_nxt;

  // Beat plan
  logic          rel_pre_r, rel_pre_nxt;
  logic          rel_post_r, rel_post_nxt;
  logic [CW-1:0] rel_len_r, rel_len_nxt;
  logic [1:0]    lit_cnt_r, lit_cnt_nxt;
  logic [7:0]    lit0_r, lit0_nxt;
  logic [7:0]    lit1_r, lit1_nxt;
  logic          stat_r;

  // Hold memory
  logic [7:0]    hold_mem [HOLD_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    rd_data_r;
  logic [CW-1:0] idx_r;

  // Output register
  logic          out_valid_r;
  out_beat_t     out_data_r;

  logic [7:0] b;
  logic       bypass;
  logic       do_idle;

  assign b      = in_data.in_byte;
  assign bypass = !chan_active_r || filter_off_r || telinfo_r;

  // Next parse state and plan for the beat on the input
  always_comb begin
    phase_nxt    = phase_r;
    skip_nxt     = skip_r;
    hold_cnt_nxt = hold_cnt_r;
    second_nxt   = second_r;
    third_nxt    = third_r;
    rowp_nxt     = rowp_r;
    model_nxt    = model_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    seen_nxt     = seen_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    rel_pre_nxt  = 1'b0;
    rel_post_nxt = 1'b0;
    rel_len_nxt  = '0;
    lit_cnt_nxt  = 2'd0;
    lit0_nxt     = 8'h00;
    lit1_nxt     = 8'h00;
    do_idle      = 1'b0;

    if (bypass) begin
      // close whatever is open, then pass the byte
      case (phase_r)
        PH_HOLD: begin
          rel_pre_nxt = 1'b1;
          rel_len_nxt = hold_cnt_r;
        end
        PH_US1: begin
          row_nxt  = CURSOR_MISSING;
          col_nxt  = CURSOR_MISSING;
          seen_nxt = 1'b1;
        end
        PH_US2: begin
          row_nxt  = rowp_r - CURSOR_BIAS;
          col_nxt  = CURSOR_MISSING;
          seen_nxt = 1'b1;
        end
        PH_ESCGS: begin
          lit0_nxt    = CH_GS;
          lit_cnt_nxt = 2'd1;
        end
        default: begin
        end
      endcase
      phase_nxt    = PH_IDLE;
      skip_nxt     = 2'd0;
      hold_cnt_nxt = '0;
      if (lit_cnt_nxt == 2'd0) lit0_nxt = b;
      else                     lit1_nxt = b;
      lit_cnt_nxt = lit_cnt_nxt + 2'd1;
    end else begin
      case (phase_r)
        PH_HOLD: begin
          if (hold_cnt_r == CW'(1)) second_nxt = b;
          if (hold_cnt_r == CW'(2)) third_nxt  = b;
          if (b == CH_EOT) begin
            model_nxt    = decode_model(third_nxt, second_nxt, model_r);
            hold_cnt_nxt = '0;
            phase_nxt    = PH_IDLE;
          end else if (hold_cnt_r < DEPTH_C) begin
            mem_we       = 1'b1;
            mem_waddr    = hold_cnt_r[AW-1:0];
            hold_cnt_nxt = hold_cnt_r + CW'(1);
          end else begin
            // store full: release it, pass this byte and the rest
            rel_pre_nxt  = 1'b1;
            rel_len_nxt  = hold_cnt_r;
            hold_cnt_nxt = '0;
            lit0_nxt     = b;
            lit_cnt_nxt  = 2'd1;
            phase_nxt    = PH_PASS;
          end
        end
        PH_US1: begin
          rowp_nxt  = b;
          phase_nxt = PH_US2;
        end
        PH_US2: begin
          row_nxt   = rowp_r - CURSOR_BIAS;
          col_nxt   = b - CURSOR_BIAS;
          seen_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
        end
        PH_ESC1: begin
          phase_nxt = PH_IDLE;
          if (b == ESC_SKIP_ONE) begin
            skip_nxt  = 2'd1;
            phase_nxt = PH_SKIP;
          end else if (b == ESC_SKIP_TWO) begin
            skip_nxt  = 2'd2;
            phase_nxt = PH_SKIP;
          end else if (b == ESC_SKIP_THREE) begin
            skip_nxt  = 2'd3;
            phase_nxt = PH_SKIP;
          end else if (b == CH_GS) begin
            phase_nxt = PH_ESCGS;
          end else if (b < ESC_KEEP_LO || b > ESC_KEEP_HI) begin
            do_idle = 1'b1;
          end else begin
            lit0_nxt    = CH_ESC;
            lit_cnt_nxt = 2'd1;
            do_idle     = 1'b1;
          end
        end
        PH_ESCGS: begin
          phase_nxt = PH_IDLE;
          if (b != CH_QUOTE) begin
            lit0_nxt    = CH_GS;
            lit_cnt_nxt = 2'd1;
            do_idle     = 1'b1;
          end
        end
        PH_SKIP: begin
          skip_nxt = (skip_r != 2'd0) ? skip_r - 2'd1 : 2'd0;
          if (skip_nxt == 2'd0) phase_nxt = PH_IDLE;
        end
        PH_PASS: begin
          lit0_nxt    = b;
          lit_cnt_nxt = 2'd1;
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // byte seen with no sequence open
      if (do_idle) begin
        if (b == CH_SOH) begin
          phase_nxt    = PH_HOLD;
          mem_we       = 1'b1;
          mem_waddr    = '0;
          hold_cnt_nxt = CW'(1);
          second_nxt   = 8'h00;
          third_nxt    = 8'h00;
        end else if (b == CH_US) begin
          phase_nxt = PH_US1;
        end else if (b == CH_ESC) begin
          phase_nxt = PH_ESC1;
        end else begin
          if (lit_cnt_nxt == 2'd0) lit0_nxt = b;
          else                     lit1_nxt = b;
          lit_cnt_nxt = lit_cnt_nxt + 2'd1;
        end
      end

      // string end closes the sequence left open
      if (in_data.end_of_string) begin
        case (phase_nxt)
          PH_HOLD: begin
            rel_post_nxt = 1'b1;
            rel_len_nxt  = hold_cnt_nxt;
          end
          PH_US1: begin
            row_nxt  = CURSOR_MISSING;
            col_nxt  = CURSOR_MISSING;
            seen_nxt = 1'b1;
          end
          PH_US2: begin
            row_nxt  = rowp_nxt - CURSOR_BIAS;
            col_nxt  = CURSOR_MISSING;
            seen_nxt = 1'b1;
          end
          PH_ESCGS: begin
            lit0_nxt    = CH_GS;
            lit_cnt_nxt = 2'd1;
          end
          default: begin
          end
        endcase
        phase_nxt    = PH_IDLE;
        skip_nxt     = 2'd0;
        hold_cnt_nxt = '0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_active_r <= 1'b1;
      filter_off_r  <= 1'b0;
      telinfo_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNEL_ACTIVE: chan_active_r <= cfg_wdata;
        CFG_FILTER_OFF:     filter_off_r  <= cfg_wdata;
        CFG_TELINFO_MODE:   telinfo_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Parse state and plan, taken on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      skip_r     <= 2'd0;
      hold_cnt_r <= '0;
      second_r   <= 8'h00;
      third_r    <= 8'h00;
      rowp_r     <= 8'h00;
      model_r    <= 8'h00;
      row_r      <= 8'h00;
      col_r      <= 8'h00;
      seen_r     <= 1'b0;
      rel_pre_r  <= 1'b0;
      rel_post_r <= 1'b0;
      rel_len_r  <= '0;
      lit_cnt_r  <= 2'd0;
      stat_r     <= 1'b0;
    end else if (cmd.accept) begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      second_r   <= second_nxt;
      third_r    <= third_nxt;
      rowp_r     <= rowp_nxt;
      model_r    <= model_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      seen_r     <= seen_nxt;
      rel_pre_r  <= rel_pre_nxt;
      rel_post_r <= rel_post_nxt;
      rel_len_r  <= rel_len_nxt;
      lit_cnt_r  <= lit_cnt_nxt;
      stat_r     <= in_data.end_of_string;
    end
  end

  // Literal bytes of the plan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lit0_r <= lit0_nxt;
      lit1_r <= lit1_nxt;
    end
  end

  // Hold memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && mem_we) hold_mem[mem_waddr] <= b;
    if (cmd.rd_en) rd_data_r <= hold_mem[idx_r[AW-1:0]];
  end

  // Release index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.accept) begin
      idx_r <= '0;
    end else if (cmd.load_mem) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_lit0 || cmd.load_lit1 || cmd.load_mem || cmd.load_stat) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_stat) begin
      out_data_r <= '{is_data: 1'b0, out_byte: 8'h00, last: 1'b1,
                      terminal_type: model_r, cursor_row: row_r,
                      cursor_col: col_r, cursor_seen: seen_r};
    end else if (cmd.load_lit0 || cmd.load_lit1 || cmd.load_mem) begin
      out_data_r <= '{is_data: 1'b1,
                      out_byte: (cmd.load_mem  ? rd_data_r :
                                 cmd.load_lit1 ? lit1_r : lit0_r),
                      last: 1'b0, terminal_type: 8'h00, cursor_row: 8'h00,
                      cursor_col: 8'h00, cursor_seen: 1'b0};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.rel_pre   = rel_pre_r;
  assign sts.rel_post  = rel_post_r;
  assign sts.lit_cnt   = lit_cnt_r;
  assign sts.has_stat  = stat_r;
  assign sts.idx_done  = (idx_r == rel_len_r);
  assign sts.slot_free = !out_valid_r || out_ready;

  // Checks
  a_rel_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rel_pre_r && rel_post_r))
    else $error("hold released both before and after the literals");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hold_cnt_r <= DEPTH_C)
    else $error("hold count beyond store depth");

  a_rel_len: assert property (@(posedge clk) disable iff (!rst_n)
    (rel_pre_r || rel_post_r) |-> (rel_len_r != '0 && rel_len_r <= DEPTH_C))
    else $error("release planned with bad length");

endmodule

/* sv/vrsf_ctrl.sv */
`timescale 1ns / 1ps
// vrsf_ctrl: sequencer that accepts one beat and then walks its plan:
// early release, literals, late release, status. Depends on vrsf_pkg.

module vrsf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output vrsf_pkg::ctrl_cmd_t cmd,
  input  vrsf_pkg::dp_sts_t   sts
);
  import vrsf_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DISP    = 4'd1;
  localparam logic [3:0] ST_PRE_RD  = 4'd2;
  localparam logic [3:0] ST_PRE_WR  = 4'd3;
  localparam logic [3:0] ST_LIT0    = 4'd4;
  localparam logic [3:0] ST_LIT1    = 4'd5;
  localparam logic [3:0] ST_POST_RD = 4'd6;
  localparam logic [3:0] ST_POST_WR = 4'd7;
  localparam logic [3:0] ST_STAT    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [3:0] after_post, after_lits, after_lit0, after_pre, from_disp;

  // next step of the plan from each point
  assign after_post = sts.has_stat ? ST_STAT : ST_IDLE;
  assign after_lits = sts.rel_post ? ST_POST_RD : after_post;
  assign after_lit0 = (sts.lit_cnt == 2'd2) ? ST_LIT1 : after_lits;
  assign after_pre  = (sts.lit_cnt != 2'd0) ? ST_LIT0 : after_lits;
  assign from_disp  = sts.rel_pre ? ST_PRE_RD : after_pre;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        state_nxt = from_disp;
      end
      ST_PRE_RD: begin
        if (sts.idx_done) begin
          state_nxt = after_pre;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_PRE_WR;
        end
      end
      ST_PRE_WR: begin
        if (sts.slot_free) begin
          cmd.load_mem = 1'b1;
          state_nxt    = ST_PRE_RD;
        end
      end
      ST_LIT0: begin
        if (sts.slot_free) begin
          cmd.load_lit0 = 1'b1;
          state_nxt     = after_lit0;
        end
      end
      ST_LIT1: begin
        if (sts.slot_free) begin
          cmd.load_lit1 = 1'b1;
          state_nxt     = after_lits;
        end
      end
      ST_POST_RD: begin
        if (sts.idx_done) begin
          state_nxt = after_post;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_POST_WR;
        end
      end
      ST_POST_WR: begin
        if (sts.slot_free) begin
          cmd.load_mem = 1'b1;
          state_nxt    = ST_POST_RD;
        end
      end
      ST_STAT: begin
        if (sts.slot_free) begin
          cmd.load_stat = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Checks
  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_DISP))
    else $error("accepted beat not followed by dispatch");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_lit0 || cmd.load_lit1 || cmd.load_mem || cmd.load_stat)
      |-> sts.slot_free)
    else $error("output register loaded while occupied");

  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !sts.idx_done)
    else $error("hold read past release length");

endmodule

/* sv/videotex_reply_sequence_filter.sv */
`timescale 1ns / 1ps
// videotex_reply_sequence_filter: top level, joins sequencer and datapath.
// Depends on vrsf_pkg, vrsf_if, vrsf_ctrl and vrsf_datapath.
//
//   port       dir   kind          beat contents
//   in_chan    in    valid/ready   in_byte, end_of_string
//   out_chan   out   valid/ready   is_data, out_byte, last, terminal_type,
//                                  cursor_row, cursor_col, cursor_seen
//   cfg_*      in    write only    cfg_we, cfg_index, cfg_wdata
//
// One input beat at a time: accept, dispatch, then the early release, the
// literals, the late release and the status beat, each output beat loaded
// when the output register is free. Releasing the hold store reads each held
// byte through the single registered read port of the hold memory, then
// loads it into the output register.
// Reset (rst_n low, synchronous) clears the sequencer, parse state and
// configuration; the hold memory is not cleared.
// A stalled output holds the sequencer; input is refused until the plan of
// the current beat has been loaded into the output register.

module videotex_reply_sequence_filter #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  vrsf_in_if.sink                        in_chan,
  vrsf_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [vrsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_wdata
);
  import vrsf_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;

  // Sequencer
  vrsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Parse state, hold memory and output register
  vrsf_datapath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_chan.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_data  (out_chan.data)
  );

  assign in_chan.ready = in_ready;

endmodule
